// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the project.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cau_pkg.sv -----
// Shared widths, opcode codes, cell payload types and the saturation function
// of the complex arithmetic unit. Depends on nothing.
package cau_pkg;

   localparam int W     = 32;           // width of one part
   localparam int F     = 16;           // fraction bits
   localparam int PW    = 2 * W;        // product width
   localparam int MW    = 2 * W;        // magnitude width after combining
   localparam int XW    = MW + F + 1;   // divide dividend width
   localparam int DW    = MW + 1;       // divisor width (twice the denominator)
   localparam int NCELL = W;            // one cell per quotient bit
   localparam logic [MW-1:0] RND = MW'(1) << (F - 1);

   typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} opcode_type;

   // One division lane as it moves from cell to cell.
   typedef struct packed {
      logic [DW-1:0] rem;
      logic [W-1:0]  xlo;
      logic [W-1:0]  quo;
   } lane_type;

   // Everything else that travels alongside the division lanes.
   typedef struct packed {
      opcode_type    op;
      logic          dz;
      logic          neg_re;
      logic          neg_im;
      logic          big_re;
      logic          big_im;
      logic [MW-1:0] mag_re;
      logic [MW-1:0] mag_im;
      logic [DW-1:0] dvs;
   } side_type;

   // Clamps a sign and magnitude to a W-bit part; the top bit is overflow.
   function automatic logic [W:0] sat(input logic neg, input logic big,
                                      input logic [MW-1:0] mag);
      logic [MW-1:0] lim;
      logic [MW-1:0] m;
      logic [W-1:0]  v;
      logic          o;
      lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
      o   = big || (mag > lim);
      m   = o ? lim : mag;
      v   = m[W-1:0];
      if (neg) begin
         v = ~v + W'(1);
      end
      return {o, v};
   endfunction

endpackage

// ----- rtl/cau_front.sv -----
// Front end of the complex arithmetic unit: products, combining and divide setup.
// Three register stages. Depends on cau_pkg.
module cau_front
   import cau_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_in,
   input  opcode_type          op_in,
   input  logic signed [W-1:0] a_re,
   input  logic signed [W-1:0] a_im,
   input  logic signed [W-1:0] b_re,
   input  logic signed [W-1:0] b_im,
   output logic                valid_out,
   output lane_type            lane_re,
   output lane_type            lane_im,
   output side_type            side
);

   // Stage A: six products and the add/subtract sums.
   logic                 va_ff;
   opcode_type           opa_ff;
   logic signed [PW-1:0] rr_ff, ii_ff, ri_ff, ir_ff, br2_ff, bi2_ff;
   logic signed [W:0]    sre_ff, sim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         opa_ff <= op_in;
         rr_ff  <= PW'(a_re) * PW'(b_re);
         ii_ff  <= PW'(a_im) * PW'(b_im);
         ri_ff  <= PW'(a_re) * PW'(b_im);
         ir_ff  <= PW'(a_im) * PW'(b_re);
         br2_ff <= PW'(b_re) * PW'(b_re);
         bi2_ff <= PW'(b_im) * PW'(b_im);
         if (op_in == OP_SUB) begin
            sre_ff <= (W+1)'(a_re) - (W+1)'(b_re);
            sim_ff <= (W+1)'(a_im) - (W+1)'(b_im);
         end else begin
            sre_ff <= (W+1)'(a_re) + (W+1)'(b_re);
            sim_ff <= (W+1)'(a_im) + (W+1)'(b_im);
         end
      end
   end

   // Stage B: combine into sign and magnitude, form the denominator.
   logic signed [MW:0] cre, cim, nre, nim;
   logic [MW-1:0]      den;
   logic               vb_ff, nre_ff, nim_ff, dzb_ff;
   opcode_type         opb_ff;
   logic [MW-1:0]      mre_ff, mim_ff, den_ff;

   always_comb begin
      case (opa_ff)
         OP_MUL: begin
            cre = (MW+1)'(rr_ff) - (MW+1)'(ii_ff);
            cim = (MW+1)'(ri_ff) + (MW+1)'(ir_ff);
         end
         OP_DIV: begin
            cre = (MW+1)'(rr_ff) + (MW+1)'(ii_ff);
            cim = (MW+1)'(ir_ff) - (MW+1)'(ri_ff);
         end
         default: begin
            cre = (MW+1)'(sre_ff);
            cim = (MW+1)'(sim_ff);
         end
      endcase
      nre = -cre;
      nim = -cim;
      den = br2_ff[MW-1:0] + bi2_ff[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         opb_ff <= opa_ff;
         nre_ff <= cre[MW];
         nim_ff <= cim[MW];
         mre_ff <= cre[MW] ? nre[MW-1:0] : cre[MW-1:0];
         mim_ff <= cim[MW] ? nim[MW-1:0] : cim[MW-1:0];
         den_ff <= den;
         dzb_ff <= (opa_ff == OP_DIV) && (den == '0);
      end
   end

   // Stage C: rounding for multiply, dividend and overflow check for divide.
   logic [XW-1:0]    xre, xim;
   logic [XW-W-1:0]  hre, him;
   logic [MW-1:0]    rre, rim;
   logic             vc_ff;
   lane_type         lre_ff, lim_ff;
   side_type         side_ff;
   side_type         side_in;

   always_comb begin
      xre = (XW'(mre_ff) << (F + 1)) + XW'(den_ff);
      xim = (XW'(mim_ff) << (F + 1)) + XW'(den_ff);
      hre = xre[XW-1:W];
      him = xim[XW-1:W];
      rre = (mre_ff + RND) >> F;
      rim = (mim_ff + RND) >> F;
      side_in.op     = opb_ff;
      side_in.dz     = dzb_ff;
      side_in.neg_re = nre_ff;
      side_in.neg_im = nim_ff;
      side_in.dvs    = {den_ff, 1'b0};
      side_in.big_re = 1'b0;
      side_in.big_im = 1'b0;
      case (opb_ff)
         OP_MUL: begin
            side_in.mag_re = rre;
            side_in.mag_im = rim;
         end
         OP_DIV: begin
            side_in.mag_re = '0;
            side_in.mag_im = '0;
            side_in.big_re = !dzb_ff && (DW'(hre) >= {den_ff, 1'b0});
            side_in.big_im = !dzb_ff && (DW'(him) >= {den_ff, 1'b0});
         end
         default: begin
            side_in.mag_re = mre_ff;
            side_in.mag_im = mim_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lre_ff.rem <= DW'(hre);
         lre_ff.xlo <= xre[W-1:0];
         lre_ff.quo <= '0;
         lim_ff.rem <= DW'(him);
         lim_ff.xlo <= xim[W-1:0];
         lim_ff.quo <= '0;
         side_ff    <= side_in;
      end
   end

   assign valid_out = vc_ff;
   assign lane_re   = lre_ff;
   assign lane_im   = lim_ff;
   assign side      = side_ff;

endmodule

// ----- rtl/cau_cell.sv -----
// One restoring-division cell: settles one quotient bit for both parts.
// Depends on cau_pkg.
module cau_cell
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     valid_in,
   input  lane_type re_in,
   input  lane_type im_in,
   input  side_type side_in,
   output logic     valid_out,
   output lane_type re_out,
   output lane_type im_out,
   output side_type side_out
);

   logic     valid_ff;
   lane_type re_ff, im_ff, re_in_n, im_in_n;
   side_type side_ff;
   logic [DW:0] r2re, r2im, dv;
   logic        gre, gim;

   // Shift in the next dividend bit, subtract the divisor where it fits.
   always_comb begin
      dv   = {1'b0, side_in.dvs};
      r2re = {re_in.rem, re_in.xlo[W-1]};
      r2im = {im_in.rem, im_in.xlo[W-1]};
      gre  = r2re >= dv;
      gim  = r2im >= dv;
      re_in_n.rem = gre ? DW'(r2re - dv) : DW'(r2re);
      im_in_n.rem = gim ? DW'(r2im - dv) : DW'(r2im);
      re_in_n.xlo = re_in.xlo << 1;
      im_in_n.xlo = im_in.xlo << 1;
      re_in_n.quo = {re_in.quo[W-2:0], gre};
      im_in_n.quo = {im_in.quo[W-2:0], gim};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re_ff   <= re_in_n;
         im_ff   <= im_in_n;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign re_out    = re_ff;
   assign im_out    = im_ff;
   assign side_out  = side_ff;

endmodule

// ----- rtl/complex_arith_unit_top.sv -----
// Throughput: one beat per cycle; the whole pipe holds while a response waits.
// The pipe is three front stages, a chain of 32 division cells (one quotient bit
// each) and the output register; a response stall stops every stage at once.
// Reset (synchronous, active high) clears every valid bit; nothing else is cleared.
module complex_arith_unit_top
   import cau_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [4*W-1:0]  req_tdata,   // a_re, a_im, b_re, b_im
   input  logic [1:0]      req_tuser,   // opcode
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [2*W-1:0]  rsp_tdata,   // res_re, res_im
   output logic [1:0]      rsp_tuser    // overflow, div_zero
);

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic     valid_chain [NCELL+1];
   lane_type re_chain    [NCELL+1];
   lane_type im_chain    [NCELL+1];
   side_type side_chain  [NCELL+1];

   // Operand products, combining and divide setup.
   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req_tvalid),
      .op_in     (opcode_type'(req_tuser)),
      .a_re      (req_tdata[W-1:0]),
      .a_im      (req_tdata[2*W-1:W]),
      .b_re      (req_tdata[3*W-1:2*W]),
      .b_im      (req_tdata[4*W-1:3*W]),
      .valid_out (valid_chain[0]),
      .lane_re   (re_chain[0]),
      .lane_im   (im_chain[0]),
      .side      (side_chain[0])
   );

   // Division cells, one quotient bit per cell.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      cau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (valid_chain[i]),
         .re_in     (re_chain[i]),
         .im_in     (im_chain[i]),
         .side_in   (side_chain[i]),
         .valid_out (valid_chain[i+1]),
         .re_out    (re_chain[i+1]),
         .im_out    (im_chain[i+1]),
         .side_out  (side_chain[i+1])
      );
   end

   // Pick the quotient for a divide, then saturate both parts.
   side_type      sl;
   logic          use_q;
   logic [MW-1:0] fre, fim;
   logic [W:0]    sre, sim;

   always_comb begin
      sl    = side_chain[NCELL];
      use_q = (sl.op == OP_DIV) && !sl.dz;
      fre   = use_q ? MW'(re_chain[NCELL].quo) : sl.mag_re;
      fim   = use_q ? MW'(im_chain[NCELL].quo) : sl.mag_im;
      sre   = sat(sl.neg_re, sl.big_re, fre);
      sim   = sat(sl.neg_im, sl.big_im, fim);
   end

   logic           rsp_valid_ff;
   logic [2*W-1:0] rsp_data_ff;
   logic [1:0]     rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_chain[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {sim[W-1:0], sre[W-1:0]};
         rsp_user_ff <= {sl.dz, sre[W] | sim[W]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/cau_checker.sv -----
// Port-level checks of the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cau_checker
   import cau_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_tvalid,
   input logic           req_tready,
   input logic [4*W-1:0] req_tdata,
   input logic [1:0]     req_tuser,
   input logic           rsp_tvalid,
   input logic           rsp_tready,
   input logic [2*W-1:0] rsp_tdata,
   input logic [1:0]     rsp_tuser
);

   localparam logic [W-1:0] PMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] NMAX = {1'b1, {(W-1){1'b0}}};

   // True when at least one part of the response sits at a limit.
   logic re_at_lim, im_at_lim, any_at_lim;
   assign re_at_lim  = (rsp_tdata[W-1:0] == PMAX) || (rsp_tdata[W-1:0] == NMAX);
   assign im_at_lim  = (rsp_tdata[2*W-1:W] == PMAX) || (rsp_tdata[2*W-1:W] == NMAX);
   assign any_at_lim = re_at_lim || im_at_lim;

   // A response beat that is held back stays offered.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped")

   // No response beat in the cycle after a reset cycle.
   `ASSERT_ALWAYS(a_rst_idle, clock, reset |=> !rsp_tvalid, "response valid after reset")

   // A divide by zero returns zero and no overflow.
   `ASSERT_CLK(a_dz_zero, clock, reset, rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0 && !rsp_tuser[0], "divide by zero result not zero")

   // Overflow means at least one part sits at a limit.
   `ASSERT_CLK(a_ovf_lim, clock, reset, rsp_tvalid && rsp_tuser[0] |-> any_at_lim, "overflow without saturated part")

   // A request beat that waits stays offered and unchanged.
   `ASSERT_CLK(a_req_hold, clock, reset, req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser), "request beat changed while waiting")

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for complex_arith_unit_top: directed and random
// complex add/sub/mul/div beats, checked against an exact-arithmetic predictor.
// Depends on cau_pkg and the complex_arith_unit_top RTL.

typedef struct {
   logic [31:0] re;
   logic [31:0] im;
   logic        ovf;
   logic        dz;
} cplx_result_type;

class complex_scoreboard;
   cplx_result_type pending[$];
   int           errors;
   int           checked;
   int           op_count[4];

   // Clamps a sign and magnitude to one Q16.16 part and flags overflow.
   function automatic logic [31:0] clamp(bit neg, logic [127:0] mag, ref logic ovf);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (mag > lim) begin
         mag = lim;
         ovf = 1'b1;
      end
      return neg ? (~mag[31:0] + 32'd1) : mag[31:0];
   endfunction

   // Works out the exact complex result and queues it.
   function void note_request(cau_pkg::opcode_type op, logic [31:0] ar, logic [31:0] ai,
                              logic [31:0] br, logic [31:0] bi);
      logic signed [127:0] xr, xi, yr, yi, vre, vim;
      logic [127:0]        mre, mim, den;
      bit                  nre, nim;
      cplx_result_type     r;
      xr = {{96{ar[31]}}, ar};
      xi = {{96{ai[31]}}, ai};
      yr = {{96{br[31]}}, br};
      yi = {{96{bi[31]}}, bi};
      r.ovf = 1'b0;
      r.dz = 1'b0;
      op_count[op]++;
      case (op)
         cau_pkg::OP_ADD: begin
            vre = xr + yr;
            vim = xi + yi;
         end
         cau_pkg::OP_SUB: begin
            vre = xr - yr;
            vim = xi - yi;
         end
         cau_pkg::OP_MUL: begin
            vre = xr * yr - xi * yi;
            vim = xr * yi + xi * yr;
         end
         default: begin
            vre = xr * yr + xi * yi;
            vim = xi * yr - xr * yi;
         end
      endcase
      nre = vre < 0;
      nim = vim < 0;
      mre = nre ? -vre : vre;
      mim = nim ? -vim : vim;
      if (op == cau_pkg::OP_MUL) begin
         // Round to nearest, ties away from zero, on the magnitude.
         mre = (mre + 128'h8000) >> 16;
         mim = (mim + 128'h8000) >> 16;
      end else if (op == cau_pkg::OP_DIV) begin
         den = yr * yr + yi * yi;
         if (den == 0) begin
            mre = 0;
            mim = 0;
            r.dz = 1'b1;
         end else begin
            mre = ((mre << 17) + den) / (den << 1);
            mim = ((mim << 17) + den) / (den << 1);
         end
      end
      if (mre == 0) nre = 0;
      if (mim == 0) nim = 0;
      r.re = clamp(nre, mre, r.ovf);
      r.im = clamp(nim, mim, r.ovf);
      pending.push_back(r);
   endfunction

   // Compares one response beat with the oldest expectation.
   function void check_response(logic [31:0] re, logic [31:0] im, logic ovf, logic dz);
      cplx_result_type e;
      if (pending.size() == 0) begin
         $error("response beat with nothing expected: re=%h im=%h", re, im);
         errors++;
         return;
      end
      e = pending.pop_front();
      checked++;
      if (re !== e.re) begin
         $error("res_re: expected %h, got %h", e.re, re);
         errors++;
      end
      if (im !== e.im) begin
         $error("res_im: expected %h, got %h", e.im, im);
         errors++;
      end
      if (ovf !== e.ovf) begin
         $error("overflow: expected %b, got %b", e.ovf, ovf);
         errors++;
      end
      if (dz !== e.dz) begin
         $error("div_zero: expected %b, got %b", e.dz, dz);
         errors++;
      end
   endfunction
endclass

module testbench;
   import cau_pkg::*;

   localparam int LATENCY     = 36;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_BEATS = 1430;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [4*W-1:0]  req_tdata = '0;
   logic [1:0]      req_tuser = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [2*W-1:0]  rsp_tdata;
   logic [1:0]      rsp_tuser;

   complex_scoreboard results = new();
   int  cycles = 0;
   bit  calm = 0;        // no idling on either side while set
   bit  draining = 0;

   complex_arith_unit_top dut (.*);

   always #2 clock = ~clock;

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  results.pending.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side: random stalls, and a check on every accepted beat.
   always @(posedge clock) begin
      if (!reset) begin
         rsp_tready <= calm || ($urandom_range(99) >= 15);
         if (rsp_tvalid && rsp_tready) begin
            results.check_response(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0],
                                   rsp_tuser[1]);
         end
      end
   end

   // Drives one request beat, with random idle cycles ahead of it.
   task automatic send_beat(opcode_type op, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {bi, br, ai, ar};
      do @(posedge clock); while (!req_tready);
      results.note_request(op, ar, ai, br, bi);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results.pending.size() != 0) @(posedge clock);
   endtask

   // Picks one part: mostly small values, with extremes and full range mixed in.
   function automatic logic [31:0] pick_part();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3, 4: return $urandom();
         5: return 32'($signed($urandom_range(65535)) - 32768);
         default: return 32'($signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000);
      endcase
   endfunction

   initial begin
      logic [31:0] mn, mx, one;
      logic [31:0] br, bi;
      mn  = 32'h8000_0000;
      mx  = 32'h7fff_ffff;
      one = 32'h0001_0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every opcode, saturation, rounding ties, divide by zero.
      send_beat(OP_ADD, mx, mn, mx, mn);
      send_beat(OP_ADD, mx, mn, 32'd1, 32'hffff_ffff);
      send_beat(OP_SUB, mn, mx, mx, mn);
      send_beat(OP_SUB, 32'd0, 32'd0, mn, mn);
      send_beat(OP_SUB, one, one, one, one);
      send_beat(OP_MUL, one, 32'd0, 32'd0, one);
      send_beat(OP_MUL, mn, mn, mn, mn);
      send_beat(OP_MUL, mx, mx, mx, mn);
      send_beat(OP_MUL, 32'h0000_8000, 32'd1, 32'd1, 32'd1);
      send_beat(OP_MUL, 32'hffff_8000, 32'd0, 32'd1, 32'd0);
      send_beat(OP_MUL, 32'h0000_0003, 32'd0, 32'h0000_8000, 32'd0);
      send_beat(OP_DIV, one, one, 32'd0, 32'd0);
      send_beat(OP_DIV, mn, mx, 32'd0, 32'd0);
      send_beat(OP_DIV, one, 32'd0, one, 32'd0);
      send_beat(OP_DIV, one, 32'd0, 32'd0, one);
      send_beat(OP_DIV, mx, mn, 32'd1, 32'd0);
      send_beat(OP_DIV, mn, mn, mn, mn);
      send_beat(OP_DIV, 32'd1, 32'd0, 32'd3, 32'd0);
      send_beat(OP_DIV, 32'hffff_ffff, 32'd0, 32'd2, 32'd0);
      send_beat(OP_DIV, 32'd5, 32'd7, mx, mn);

      // Hold off until the pipe has fully drained once.
      wait_drained();

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         calm = (i >= 500 && i < 800);
         br = pick_part();
         bi = pick_part();
         if ($urandom_range(19) == 0) begin
            br = 32'd0;
            bi = 32'd0;
         end
         send_beat(opcode_type'($urandom_range(3)), pick_part(), pick_part(), br, bi);
      end
      calm = 0;
      wait_drained();
      repeat (LATENCY + 8) @(posedge clock);

      $display("Covered %0d results: %0d add, %0d sub, %0d mul, %0d div beats,",
               results.checked, results.op_count[0], results.op_count[1],
               results.op_count[2], results.op_count[3]);
      $display("with saturation, rounding ties and zero divisors under random stalls.");
      if (results.errors == 0 && results.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/complex_arith_unit_top.sv
rtl/cau_checker.sv
tb/testbench.sv
